### rtl/asfft_pkg.sv
// ----------------------------------------------------------------------------
// asfft_pkg
// Shared types, constants and twiddle tables of the 32-point spectrum core.
// ----------------------------------------------------------------------------
package asfft_pkg;

  localparam int POINTS      = 32;
  localparam int ADDR_W      = 5;
  localparam int SAMPLE_W    = 16;
  localparam int STORE_W     = 20;
  localparam int MAG_W       = 16;
  localparam int TW_W        = 30;
  localparam int PROD_W      = 55;
  localparam int POWER_W     = 40;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [STORE_W-1:0] store_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    addr_t load_addr;
    addr_t rd_a;
    addr_t rd_b;
    logic  mul;
    logic  [3:0] tw_idx;
    logic  bfly;
    addr_t wr_a;
    addr_t wr_b;
    logic  root_start;
    logic  peak_clr;
    logic  peak_upd;
    logic  mag_wr;
    addr_t mag_addr;
  } ctl_t;

  typedef struct packed {
    logic root_done;
  } sts_t;

  function automatic logic signed [TW_W-1:0] sin_q28(input logic [3:0] p);
    case (p)
      4'd0:    sin_q28 = 30'sd0;
      4'd1:    sin_q28 = 30'sd52369073;
      4'd2:    sin_q28 = 30'sd102725686;
      4'd3:    sin_q28 = 30'sd149134686;
      4'd4:    sin_q28 = 30'sd189812590;
      4'd5:    sin_q28 = 30'sd223196029;
      4'd6:    sin_q28 = 30'sd248002149;
      4'd7:    sin_q28 = 30'sd263277469;
      4'd8:    sin_q28 = 30'sd268435456;
      4'd9:    sin_q28 = 30'sd263277469;
      4'd10:   sin_q28 = 30'sd248002149;
      4'd11:   sin_q28 = 30'sd223196029;
      4'd12:   sin_q28 = 30'sd189812590;
      4'd13:   sin_q28 = 30'sd149134686;
      4'd14:   sin_q28 = 30'sd102725686;
      default: sin_q28 = 30'sd52369073;
    endcase
  endfunction

  function automatic logic signed [TW_W-1:0] cos_q28(input logic [3:0] p);
    case (p)
      4'd0:    cos_q28 = 30'sd268435456;
      4'd1:    cos_q28 = 30'sd263277469;
      4'd2:    cos_q28 = 30'sd248002149;
      4'd3:    cos_q28 = 30'sd223196029;
      4'd4:    cos_q28 = 30'sd189812590;
      4'd5:    cos_q28 = 30'sd149134686;
      4'd6:    cos_q28 = 30'sd102725686;
      4'd7:    cos_q28 = 30'sd52369073;
      4'd8:    cos_q28 = 30'sd0;
      4'd9:    cos_q28 = -30'sd52369072;
      4'd10:   cos_q28 = -30'sd102725685;
      4'd11:   cos_q28 = -30'sd149134685;
      4'd12:   cos_q28 = -30'sd189812589;
      4'd13:   cos_q28 = -30'sd223196028;
      4'd14:   cos_q28 = -30'sd248002148;
      default: cos_q28 = -30'sd263277468;
    endcase
  endfunction

  function automatic addr_t rev5(input addr_t i);
    rev5 = {i[0], i[1], i[2], i[3], i[4]};
  endfunction

endpackage

### rtl/asfft_ram.sv
// ----------------------------------------------------------------------------
// asfft_ram
// Generic single-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asfft_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/asfft_dp.sv
// ----------------------------------------------------------------------------
// asfft_dp
// Datapath: shared sample/spectrum store, twiddle multipliers, butterfly,
// bit-serial square root, magnitude store and peak register.
// ----------------------------------------------------------------------------
module asfft_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  asfft_pkg::ctl_t                     ctl,
  input  logic signed [asfft_pkg::SAMPLE_W-1:0] sample,
  output asfft_pkg::sts_t                     sts,
  output logic [asfft_pkg::MAG_W-1:0]         mag,
  output logic [asfft_pkg::MAG_W-1:0]         peak
);

  localparam int SW = asfft_pkg::STORE_W;
  localparam int PW = asfft_pkg::PROD_W;
  localparam int QW = asfft_pkg::POWER_W;
  localparam int MW = asfft_pkg::MAG_W;

  // One store word holds real and imaginary parts; a butterfly writes two words.
  logic            we_r;
  asfft_pkg::addr_t waddr;
  logic [2*SW-1:0] wdata;
  logic [2*SW-1:0] rd_a, rd_b;
  asfft_pkg::addr_t raddr_a, raddr_b;

  // Second butterfly output is written in the next cycle from a holding register.
  logic              pend_r;
  asfft_pkg::addr_t  pend_addr_r;
  logic [2*SW-1:0]   pend_data_r;

  asfft_ram #(.WIDTH(2*SW), .DEPTH(asfft_pkg::POINTS)) u_store (
    .clk     (clk),
    .we      (we_r),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign raddr_a = ctl.rd_a;
  assign raddr_b = ctl.rd_b;

  logic signed [SW-1:0] ar_r, ai_r;
  logic signed [PW-1:0] p_xc_r, p_ys_r, p_yc_r, p_xs_r;
  logic signed [SW+1:0] t_w, u_w, s0r, s0i, s1r, s1i;
  logic signed [SW-1:0] n0r, n0i, n1r, n1i;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      ar_r   <= rd_a[2*SW-1:SW];
      ai_r   <= rd_a[SW-1:0];
      p_xc_r <= PW'($signed(rd_b[2*SW-1:SW]) * asfft_pkg::cos_q28(ctl.tw_idx));
      p_ys_r <= PW'($signed(rd_b[SW-1:0]) * asfft_pkg::sin_q28(ctl.tw_idx));
      p_yc_r <= PW'($signed(rd_b[SW-1:0]) * asfft_pkg::cos_q28(ctl.tw_idx));
      p_xs_r <= PW'($signed(rd_b[2*SW-1:SW]) * asfft_pkg::sin_q28(ctl.tw_idx));
    end
  end

  // floor(x*c / 2^28) for each product.
  assign t_w = (SW+2)'(p_xc_r >>> 28) + (SW+2)'(p_ys_r >>> 28);
  assign u_w = (SW+2)'(p_yc_r >>> 28) - (SW+2)'(p_xs_r >>> 28);
  assign s0r = (SW+2)'(ar_r) + t_w;
  assign s0i = (SW+2)'(ai_r) + u_w;
  assign s1r = (SW+2)'(ar_r) - t_w;
  assign s1i = (SW+2)'(ai_r) - u_w;
  assign n0r = s0r[SW:1];
  assign n0i = s0i[SW:1];
  assign n1r = s1r[SW:1];
  assign n1i = s1i[SW:1];

  always_comb begin
    we_r  = 1'b0;
    waddr = ctl.load_addr;
    wdata = {SW'(sample), {SW{1'b0}}};
    if (ctl.load) begin
      we_r = 1'b1;
    end else if (ctl.bfly) begin
      we_r  = 1'b1;
      waddr = ctl.wr_a;
      wdata = {n0r, n0i};
    end else if (pend_r) begin
      we_r  = 1'b1;
      waddr = pend_addr_r;
      wdata = pend_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= ctl.bfly;
    end
    if (ctl.bfly) begin
      pend_addr_r <= ctl.wr_b;
      pend_data_r <= {n1r, n1i};
    end
  end

  // Power: squares registered, then summed, then rooted one bit per cycle.
  logic [QW-1:0] sq_r_r, sq_i_r;
  logic [QW-1:0] rem_r, rem_nxt;
  logic [MW-1:0] root_r, root_nxt;
  logic [4:0]    step_r;
  logic          run_r, sq_p_r, sq_v_r;
  logic [QW-1:0] trial;
  logic [MW-1:0] bit_w;

  always_ff @(posedge clk) begin
    sq_r_r <= QW'($signed(rd_a[2*SW-1:SW]) * $signed(rd_a[2*SW-1:SW]));
    sq_i_r <= QW'($signed(rd_a[SW-1:0]) * $signed(rd_a[SW-1:0]));
  end

  assign bit_w = MW'(1) << step_r[3:0];
  assign trial = ((QW'(root_r) << 1) + QW'(bit_w)) << step_r[3:0];

  always_comb begin
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (rem_r >= trial) begin
      rem_nxt  = rem_r - trial;
      root_nxt = root_r | bit_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      sq_p_r <= 1'b0;
      sq_v_r <= 1'b0;
      step_r <= '0;
    end else begin
      sq_p_r <= ctl.root_start;
      sq_v_r <= sq_p_r;
      if (sq_v_r) begin
        run_r  <= 1'b1;
        step_r <= 5'd15;
      end else if (run_r) begin
        if (step_r == 5'd0) begin
          run_r <= 1'b0;
        end
        step_r <= step_r - 5'd1;
      end
    end
    if (sq_v_r) begin
      rem_r  <= sq_r_r + sq_i_r;
      root_r <= '0;
    end else if (run_r) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign sts.root_done = run_r && (step_r == 5'd0);

  logic [MW-1:0] mag_w;
  logic [MW-1:0] peak_r;
  assign mag_w = {root_nxt[MW-2:0], 1'b0};

  asfft_ram #(.WIDTH(MW), .DEPTH(asfft_pkg::POINTS)) u_mag (
    .clk     (clk),
    .we      (ctl.mag_wr),
    .waddr   (ctl.mag_addr),
    .wdata   (mag_w),
    .raddr_a (ctl.mag_addr),
    .raddr_b (ctl.mag_addr),
    .rdata_a (mag),
    .rdata_b ()
  );

  always_ff @(posedge clk) begin
    if (ctl.peak_clr) begin
      peak_r <= '0;
    end else if (ctl.peak_upd && mag_w > peak_r) begin
      peak_r <= mag_w;
    end
  end

  assign peak = peak_r;

endmodule

### rtl/asfft_ctrl.sv
// ----------------------------------------------------------------------------
// asfft_ctrl
// Controller: sample loading, butterfly scheduling, root sequencing and
// result emission.
// ----------------------------------------------------------------------------
module asfft_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  asfft_pkg::sts_t  sts,
  output asfft_pkg::ctl_t  ctl,
  output logic             out_valid,
  output logic [asfft_pkg::ADDR_W-1:0] out_bin,
  output logic             out_last
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_BRD  = 3'd1;
  localparam logic [2:0] S_BMUL = 3'd2;
  localparam logic [2:0] S_BWR  = 3'd3;
  localparam logic [2:0] S_BFL  = 3'd4;
  localparam logic [2:0] S_RRD  = 3'd5;
  localparam logic [2:0] S_RWT  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [4:0] fill_r;
  logic [2:0] lvl_r;
  logic [3:0] bf_r;
  logic [4:0] idx_r;
  logic       emit_v_r;
  logic [4:0] emit_bin_r;

  // Butterfly bf in level L (0..4): group j = bf mod 2^L, block = bf >> L.
  logic [4:0] half, jj, kk, ka, kb;
  logic [3:0] tw;
  assign half = 5'd1 << lvl_r;
  assign jj   = {1'b0, bf_r} & (half - 5'd1);
  assign kk   = (({1'b0, bf_r} >> lvl_r) << (lvl_r + 3'd1));
  assign ka   = kk | jj;
  assign kb   = ka | half;
  assign tw   = 4'(jj << (3'd4 - lvl_r));

  always_comb begin
    ctl            = '0;
    ctl.load_addr  = asfft_pkg::rev5(fill_r);
    ctl.rd_a       = ka;
    ctl.rd_b       = kb;
    ctl.tw_idx     = tw;
    ctl.wr_a       = ka;
    ctl.wr_b       = kb;
    ctl.mag_addr   = idx_r;
    state_nxt      = state_r;
    case (state_r)
      S_LOAD: begin
        if (start) begin
          ctl.load = 1'b1;
          if (fill_r == 5'd31) begin
            state_nxt = S_BRD;
          end
        end
      end
      S_BRD: begin
        state_nxt = S_BMUL;
      end
      S_BMUL: begin
        ctl.mul   = 1'b1;
        state_nxt = S_BWR;
      end
      S_BWR: begin
        ctl.bfly  = 1'b1;
        state_nxt = S_BFL;
      end
      S_BFL: begin
        if (bf_r == 4'd15 && lvl_r == 3'd4) begin
          state_nxt    = S_RRD;
          ctl.peak_clr = 1'b1;
        end else begin
          state_nxt = S_BRD;
        end
      end
      S_RRD: begin
        ctl.rd_a       = idx_r;
        ctl.root_start = 1'b1;
        state_nxt      = S_RWT;
      end
      S_RWT: begin
        if (sts.root_done) begin
          ctl.mag_wr   = 1'b1;
          ctl.peak_upd = 1'b1;
          state_nxt    = (idx_r == 5'd31) ? S_EMIT : S_RRD;
        end
      end
      S_EMIT: begin
        if (idx_r == 5'd31) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      fill_r   <= '0;
      lvl_r    <= '0;
      bf_r     <= '0;
      idx_r    <= '0;
      emit_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      emit_v_r <= (state_r == S_EMIT);
      if (ctl.load) begin
        fill_r <= fill_r + 5'd1;
      end
      if (state_r == S_BFL) begin
        bf_r <= bf_r + 4'd1;
        if (bf_r == 4'd15) begin
          lvl_r <= (lvl_r == 3'd4) ? 3'd0 : lvl_r + 3'd1;
        end
      end
      if ((state_r == S_RWT && sts.root_done) || state_r == S_EMIT) begin
        idx_r <= idx_r + 5'd1;
      end
    end
    emit_bin_r <= idx_r;
  end

  assign busy      = (state_r != S_LOAD);
  assign out_valid = emit_v_r;
  assign out_bin   = emit_bin_r;
  assign out_last  = emit_v_r && (emit_bin_r == 5'd31);

`ifndef SYNTHESIS
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> state_r == S_LOAD) else $error("load outside idle");
  a_bfly_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.bfly |-> $past(ctl.mul)) else $error("butterfly without products");
  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid) else $error("last without strobe");
`endif

endmodule

### rtl/audio_spectrum_fft32_core.sv
// ----------------------------------------------------------------------------
// audio_spectrum_fft32_core
// 32-point fixed-point FFT with per-bin magnitude and frame peak.
//
//  channel  | ports                                   | handshake
//  input    | start, busy, in_sample                  | start && !busy
//  result   | out_valid, out_bin, out_magnitude,      | out_valid, one cycle
//           | out_peak, out_last                      |
//
// A sample is taken whenever start is high while a frame loads. The 32nd
// sample starts 80 butterflies (states S_BRD, S_BMUL, S_BWR, S_BFL), then
// 32 roots (a read, forming the power, sixteen root steps), then 32
// results on consecutive cycles; busy is high over all of it but the last
// result. Reset returns to an empty frame. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module audio_spectrum_fft32_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_sample,
  output logic        out_valid,
  output logic [4:0]  out_bin,
  output logic [15:0] out_magnitude,
  output logic [15:0] out_peak,
  output logic        out_last
);

  asfft_pkg::ctl_t ctl;
  asfft_pkg::sts_t sts;

  asfft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .sts       (sts),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_bin   (out_bin),
    .out_last  (out_last)
  );

  asfft_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample ($signed(in_sample)),
    .sts    (sts),
    .mag    (out_magnitude),
    .peak   (out_peak)
  );

endmodule

### tb/tb_audio_spectrum_fft32_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_spectrum_fft32_core
// Self-checking bench for the 32-point spectrum core. Samples are sent with
// random gaps, a software model of the transform predicts the 32 bin results
// of every frame, and a scoreboard compares each result field by field.
// ----------------------------------------------------------------------------
class spectrum_scoreboard;
  typedef struct packed {
    logic [4:0]  bin;
    logic [15:0] magnitude;
    logic [15:0] peak;
    logic        last;
  } bin_result_t;

  longint      frame_re[32];
  longint      frame_im[32];
  int unsigned fill_count;
  bin_result_t pending_bins[$];
  int unsigned errors;

  function new();
    fill_count = 0;
    errors = 0;
    for (int i = 0; i < 32; i++) begin
      frame_re[i] = 0;
      frame_im[i] = 0;
    end
  endfunction

  function automatic longint floor_shift(longint x, int n);
    floor_shift = x >>> n;
  endfunction

  function automatic longint wrap20(longint v);
    logic signed [19:0] w;
    w = v[19:0];
    wrap20 = w;
  endfunction

  function automatic longint twiddle_mul(longint x, longint c);
    twiddle_mul = ((x * 16) * c) >>> 32;
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned n;
    longint unsigned b;
    longint unsigned t;
    int sh;
    n = 0;
    b = 16'h8000;
    sh = 15;
    while (b != 0) begin
      t = ((n << 1) + b) << sh;
      if (v >= t) begin
        n += b;
        v -= t;
      end
      b >>= 1;
      if (sh > 0) sh--;
    end
    int_root = n;
  endfunction

  function void run_transform();
    longint ar, ai, xr, xi, t, u, cs, sn;
    int b, p;
    for (int stage = 1; stage <= 5; stage++) begin
      b = 1 << (stage - 1);
      for (int j = 0; j < b; j++) begin
        p = (j << (5 - stage)) & 15;
        cs = asfft_pkg::cos_q28(p[3:0]);
        sn = asfft_pkg::sin_q28(p[3:0]);
        for (int k = j; k + b < 32; k += 2 * b) begin
          ar = frame_re[k];
          ai = frame_im[k];
          xr = frame_re[k + b];
          xi = frame_im[k + b];
          t = twiddle_mul(xr, cs) + twiddle_mul(xi, sn);
          u = twiddle_mul(xi, cs) - twiddle_mul(xr, sn);
          frame_re[k] = wrap20(floor_shift(ar + t, 1));
          frame_im[k] = wrap20(floor_shift(ai + u, 1));
          frame_re[k + b] = wrap20(floor_shift(ar - t, 1));
          frame_im[k + b] = wrap20(floor_shift(ai - u, 1));
        end
      end
    end
  endfunction

  function void note_sample(logic [15:0] sample);
    logic [4:0] idx;
    logic [4:0] addr;
    logic [15:0] mags[32];
    logic [15:0] peak;
    bin_result_t r;
    idx = fill_count[4:0];
    addr = {idx[0], idx[1], idx[2], idx[3], idx[4]};
    frame_re[addr] = longint'($signed(sample));
    frame_im[addr] = 0;
    fill_count++;
    if (fill_count < 32) return;
    fill_count = 0;
    run_transform();
    peak = 0;
    for (int i = 0; i < 32; i++) begin
      mags[i] = 16'(int_root(frame_re[i] * frame_re[i] + frame_im[i] * frame_im[i]) << 1);
      if (mags[i] > peak) peak = mags[i];
    end
    for (int i = 0; i < 32; i++) begin
      r.bin = i[4:0];
      r.magnitude = mags[i];
      r.peak = peak;
      r.last = (i == 31);
      pending_bins.push_back(r);
    end
  endfunction

  function void check_result(logic [4:0] bin, logic [15:0] magnitude, logic [15:0] peak,
                             logic last);
    bin_result_t e;
    if (pending_bins.size() == 0) begin
      $error("unexpected result transaction: bin %0d", bin);
      errors++;
      return;
    end
    e = pending_bins.pop_front();
    if (bin !== e.bin) begin
      $error("bin: expected %0d, actual %0d", e.bin, bin);
      errors++;
    end
    if (magnitude !== e.magnitude) begin
      $error("magnitude: expected %0d, actual %0d", e.magnitude, magnitude);
      errors++;
    end
    if (peak !== e.peak) begin
      $error("peak: expected %0d, actual %0d", e.peak, peak);
      errors++;
    end
    if (last !== e.last) begin
      $error("last: expected %0d, actual %0d", e.last, last);
      errors++;
    end
  endfunction
endclass

module tb_audio_spectrum_fft32_core;
  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_sample;
  logic        out_valid;
  logic [4:0]  out_bin;
  logic [15:0] out_magnitude;
  logic [15:0] out_peak;
  logic        out_last;

  spectrum_scoreboard sb;
  int idle_pct;

  audio_spectrum_fft32_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_bin      (out_bin),
    .out_magnitude(out_magnitude),
    .out_peak     (out_peak),
    .out_last     (out_last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_sample(in_sample);
    if (rst_n && out_valid) sb.check_result(out_bin, out_magnitude, out_peak, out_last);
  end

  task automatic send_sample(logic [15:0] s);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(int kind);
    logic [15:0] s;
    for (int i = 0; i < 32; i++) begin
      case (kind)
        0: s = 16'h7fff;
        1: s = 16'h8000;
        2: s = i[0] ? 16'h8000 : 16'h7fff;
        3: s = 16'h0000;
        4: s = i == 0 ? 16'h7fff : 16'h0000;
        5: s = $urandom_range(8) == 0 ? (i[1] ? 16'h7fff : 16'h8000) : 16'($urandom);
        default: s = 16'($signed($urandom_range(400)) - 200);
      endcase
      send_sample(s);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_sample = '0;
    idle_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int k = 0; k < 5; k++) send_frame(k);
    start <= 1'b0;
    while (sb.pending_bins.size() != 0) @(posedge clk);
    @(negedge clk);
    for (int f = 0; f < 8; f++) begin
      case (f % 4)
        0: idle_pct = 0;
        1: idle_pct = 74;
        2: idle_pct = 74;
        default: idle_pct = 6;
      endcase
      send_frame($urandom_range(4) == 0 ? 6 : 5);
    end
    start <= 1'b0;
    while (sb.pending_bins.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_bins.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
